### hw/rtl/bfd_pkg.sv
package bfd_pkg;

	localparam logic [7:0]  PRE_FIRST      = 8'h0A;
	localparam logic [7:0]  PRE_SECOND     = 8'h0B;
	localparam logic [15:0] MAX_SIZE_RESET = 16'd1000;
	localparam logic [15:0] MIN_SIZE       = 16'd2;
	// summed region starts with the four header bytes
	localparam logic [16:0] HDR_BYTES      = 17'd4;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CHECK   = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		HS_PRE1    = 3'd0,
		HS_PRE2    = 3'd1,
		HS_SIZE_LO = 3'd2,
		HS_SIZE_HI = 3'd3,
		HS_TYPE_LO = 3'd4,
		HS_TYPE_HI = 3'd5
	} hdr_step_t;

	typedef enum logic [1:0] {
		ST_NONE      = 2'd0,
		ST_GOOD      = 2'd1,
		ST_SIZE_ERR  = 2'd2,
		ST_CKSUM_ERR = 2'd3
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] frame_type;
		logic [15:0] frame_size;
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic [31:0] errors_total;
	} res_t;

endpackage

### hw/rtl/bfd_if.sv
interface bfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

interface bfd_res_if;
	logic              valid;
	logic              ready;
	bfd_pkg::status_t  status;
	logic [15:0]       frame_type;
	logic [15:0]       frame_size;
	logic              payload_valid;
	logic [7:0]        payload_byte;
	logic [15:0]       payload_index;
	logic [31:0]       errors_total;

	modport source(output valid, output status, output frame_type, output frame_size,
		output payload_valid, output payload_byte, output payload_index,
		output errors_total, input ready);
	modport sink(input valid, input status, input frame_type, input frame_size,
		input payload_valid, input payload_byte, input payload_index,
		input errors_total, output ready);
endinterface

interface bfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/bfd_in_reg.sv
module bfd_in_reg (
	input  logic         clk,
	input  logic         arst_n,
	bfd_byte_if.sink     bytes,
	input  logic         step,
	output logic         valid_s1,
	output logic [7:0]   byte_s1
);

	// slot frees when the held byte is consumed in the same cycle
	assign bytes.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.in_byte;
		end
	end

endmodule

### hw/rtl/bfd_fsm.sv
module bfd_fsm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    byte_s1,
	input  logic [15:0]   max_size,
	output bfd_pkg::res_t res_d
);

	bfd_pkg::phase_t    phase_q, phase_d;
	bfd_pkg::hdr_step_t hstep_q, hstep_d;
	logic [15:0] size_q, size_d;
	logic [15:0] type_q, type_d;
	logic [16:0] pos_q, pos_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  ck_lo_q, ck_lo_d;
	logic        ck_half_q, ck_half_d;
	logic [31:0] err_q, err_d;

	logic [15:0] size_full;
	logic [15:0] cks;
	logic [15:0] add_val;
	logic [16:0] pos_inc;
	logic [16:0] pos_rel;

	assign size_full = {byte_s1, size_q[7:0]};
	assign cks       = {byte_s1, ck_lo_q};
	assign add_val   = pos_q[0] ? {byte_s1, 8'h00} : {8'h00, byte_s1};
	assign pos_inc   = pos_q + 17'd1;
	assign pos_rel   = pos_q - bfd_pkg::HDR_BYTES;

	always_comb begin
		phase_d   = phase_q;
		hstep_d   = hstep_q;
		size_d    = size_q;
		type_d    = type_q;
		pos_d     = pos_q;
		sum_d     = sum_q;
		ck_lo_d   = ck_lo_q;
		ck_half_d = ck_half_q;
		err_d     = err_q;

		res_d.status        = bfd_pkg::ST_NONE;
		res_d.payload_valid = 1'b0;
		res_d.payload_byte  = 8'h00;
		res_d.payload_index = 16'h0000;

		unique case (phase_q)
			bfd_pkg::PH_PAYLOAD: begin
				res_d.payload_valid = 1'b1;
				res_d.payload_byte  = byte_s1;
				res_d.payload_index = pos_rel[15:0];
				sum_d = sum_q + add_val;
				pos_d = pos_inc;
				if (pos_inc == ({1'b0, size_q} + 17'd2)) begin
					phase_d = bfd_pkg::PH_CHECK;
				end
			end
			bfd_pkg::PH_CHECK: begin
				if (!ck_half_q) begin
					ck_lo_d   = byte_s1;
					ck_half_d = 1'b1;
				end else begin
					ck_half_d = 1'b0;
					phase_d   = bfd_pkg::PH_HUNT;
					hstep_d   = bfd_pkg::HS_PRE1;
					if (16'(sum_q + cks) == 16'h0000) begin
						res_d.status = bfd_pkg::ST_GOOD;
					end else begin
						res_d.status = bfd_pkg::ST_CKSUM_ERR;
						err_d = err_q + 32'd1;
					end
				end
			end
			default: begin
				phase_d = bfd_pkg::PH_HUNT;
				unique case (hstep_q)
					bfd_pkg::HS_PRE1: begin
						if (byte_s1 == bfd_pkg::PRE_FIRST) begin
							hstep_d = bfd_pkg::HS_PRE2;
						end
					end
					bfd_pkg::HS_PRE2: begin
						hstep_d = (byte_s1 == bfd_pkg::PRE_SECOND) ?
							bfd_pkg::HS_SIZE_LO : bfd_pkg::HS_PRE1;
					end
					bfd_pkg::HS_SIZE_LO: begin
						size_d  = {8'h00, byte_s1};
						type_d  = 16'h0000;
						sum_d   = 16'h0000;
						hstep_d = bfd_pkg::HS_SIZE_HI;
					end
					bfd_pkg::HS_SIZE_HI: begin
						size_d = size_full;
						if (size_full > max_size || size_full < bfd_pkg::MIN_SIZE) begin
							res_d.status = bfd_pkg::ST_SIZE_ERR;
							err_d   = err_q + 32'd1;
							hstep_d = bfd_pkg::HS_PRE1;
						end else begin
							sum_d   = size_full;
							hstep_d = bfd_pkg::HS_TYPE_LO;
						end
					end
					bfd_pkg::HS_TYPE_LO: begin
						type_d  = {8'h00, byte_s1};
						hstep_d = bfd_pkg::HS_TYPE_HI;
					end
					bfd_pkg::HS_TYPE_HI: begin
						type_d    = {byte_s1, type_q[7:0]};
						sum_d     = sum_q + {byte_s1, type_q[7:0]};
						pos_d     = bfd_pkg::HDR_BYTES;
						ck_half_d = 1'b0;
						hstep_d   = bfd_pkg::HS_PRE1;
						// empty payload goes straight to the checksum
						phase_d   = (size_q == bfd_pkg::MIN_SIZE) ?
							bfd_pkg::PH_CHECK : bfd_pkg::PH_PAYLOAD;
					end
					default: begin
						hstep_d = bfd_pkg::HS_PRE1;
					end
				endcase
			end
		endcase

		res_d.frame_type   = type_d;
		res_d.frame_size   = size_d;
		res_d.errors_total = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= bfd_pkg::PH_HUNT;
			hstep_q   <= bfd_pkg::HS_PRE1;
			size_q    <= 16'h0000;
			type_q    <= 16'h0000;
			pos_q     <= 17'h00000;
			sum_q     <= 16'h0000;
			ck_lo_q   <= 8'h00;
			ck_half_q <= 1'b0;
			err_q     <= 32'h0000_0000;
		end else if (step) begin
			phase_q   <= phase_d;
			hstep_q   <= hstep_d;
			size_q    <= size_d;
			type_q    <= type_d;
			pos_q     <= pos_d;
			sum_q     <= sum_d;
			ck_lo_q   <= ck_lo_d;
			ck_half_q <= ck_half_d;
			err_q     <= err_d;
		end
	end

	a_payload_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_d.payload_valid |-> res_d.status == bfd_pkg::ST_NONE)
		else $error("payload byte carries a frame status");

	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && (res_d.status == bfd_pkg::ST_SIZE_ERR ||
			res_d.status == bfd_pkg::ST_CKSUM_ERR)
		|=> err_q == $past(err_q) + 32'd1)
		else $error("error counter missed an error");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == bfd_pkg::PH_PAYLOAD |-> pos_q < ({1'b0, size_q} + 17'd2))
		else $error("payload position ran past frame end");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(err_q) && $stable(pos_q))
		else $error("state moved without a transaction");

endmodule

### hw/rtl/bfd_out_reg.sv
module bfd_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load_valid,
	input  bfd_pkg::res_t res_d,
	output logic          space,
	bfd_res_if.source     results
);

	bfd_pkg::res_t res_q;

	assign space = !results.valid || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.valid <= 1'b0;
		end else if (space) begin
			results.valid <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load_valid) begin
			res_q <= res_d;
		end
	end

	assign results.status        = res_q.status;
	assign results.frame_type    = res_q.frame_type;
	assign results.frame_size    = res_q.frame_size;
	assign results.payload_valid = res_q.payload_valid;
	assign results.payload_byte  = res_q.payload_byte;
	assign results.payload_index = res_q.payload_index;
	assign results.errors_total  = res_q.errors_total;

endmodule

### hw/rtl/byte_frame_deframer_wordsum.sv
// a byte accepted into the input register reaches the outputs once the result register has space
// throughput: one byte per cycle while results.ready does not stall the output;
//   the frame state updates as the input register hands its byte to the result register
// reset: arst_n clears the frame state, error count and valid flags at once,
//   max_size returns to 1000; no clearing pass is needed
module byte_frame_deframer_wordsum (
	input  logic      clk,
	input  logic      arst_n,
	bfd_byte_if.sink  bytes,
	bfd_cfg_if.sink   cfg,
	bfd_res_if.source results
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          space;
	logic          step;
	logic [15:0]   max_size_q;
	bfd_pkg::res_t res_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= bfd_pkg::MAX_SIZE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			max_size_q <= cfg.data;
		end
	end

	// a transaction moves from the input register into the result register
	assign step = valid_s1 && space;

	bfd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes),
		.step     (step),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	bfd_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.byte_s1  (byte_s1),
		.max_size (max_size_q),
		.res_d    (res_d)
	);

	bfd_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.res_d      (res_d),
		.space      (space),
		.results    (results)
	);

endmodule
